FILE: rtl/core/sefx_pkg.sv
// ----------------------------------------------------------------------------
// sefx_pkg
// Shared types and constants for the start/end marker frame extractor.
// ----------------------------------------------------------------------------
package sefx_pkg;

   // Frame layout: start, type, length, payload, check, end
   localparam int unsigned FRAME_OVERHEAD = 5;
   localparam int unsigned LEN_OFFSET     = 2;
   localparam int unsigned END_OFFSET     = FRAME_OVERHEAD - 1;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LIMIT_W = 6;
   localparam int unsigned SIZE_W  = 7;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_START_MARKER  = 2'd0,
      REG_END_MARKER    = 2'd1,
      REG_PAYLOAD_LIMIT = 2'd2
   } csr_index_type;

   localparam logic [BYTE_W-1:0]  START_MARKER_RESET  = 8'hfa;
   localparam logic [BYTE_W-1:0]  END_MARKER_RESET    = 8'hf5;
   localparam logic [LIMIT_W-1:0] PAYLOAD_LIMIT_RESET = 6'd59;

   // Per-cell control from the sequencer
   typedef struct packed {
      logic shift;   // take the right neighbor's byte
      logic load;    // take the incoming byte
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

FILE: rtl/core/sefx_cell.sv
// ----------------------------------------------------------------------------
// sefx_cell
// One byte cell of the window chain: holds, loads a new byte, or shifts
// in its right neighbor's byte.
// ----------------------------------------------------------------------------
module sefx_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  sefx_pkg::cell_ctl_type      ctl,
   input  logic [sefx_pkg::BYTE_W-1:0] load_data,
   input  logic [sefx_pkg::BYTE_W-1:0] right_data,
   output logic [sefx_pkg::BYTE_W-1:0] cell_byte
);

   logic [sefx_pkg::BYTE_W-1:0] data_ff;
   logic [sefx_pkg::BYTE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.shift) begin
         data_in = right_data;
      end else if (ctl.load) begin
         data_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign cell_byte = data_ff;

endmodule

FILE: rtl/core/stx_etx_frame_extractor.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_extractor
// Deframer for start/type/length/payload/check/end frames over a byte window.
// ----------------------------------------------------------------------------
// Each req_ transaction appends one received byte to a window of up to
// WINDOW_BYTES bytes, held in a chain of byte cells (oldest in cell 0; a full
// window slides out its oldest byte). After a plain byte the block stays
// ready, so plain bytes stream at one per cycle while no search or frame is
// in progress. A search is only needed when the new byte equals the end
// marker, or on the first byte after any csr_ write: the head cell is then
// checked as a frame start (the candidate's end byte is first fetched into a
// register, then checked), and on a miss the chain rotates one cell. A search
// that finds no frame rotates the chain full circle, which restores byte
// order. The earliest complete frame (start marker, length byte within
// payload_limit, whole frame held, end marker at its end) is sent out of cell
// 0 one byte per rsp_ transaction, rsp_frame_last on the end marker, and then
// all held bytes are dropped. The check byte is not verified. No req_
// transaction is taken while a search or a frame is in progress.
// ----------------------------------------------------------------------------
module stx_etx_frame_extractor #(
   parameter int WINDOW_BYTES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // byte input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sefx_pkg::BYTE_W-1:0]       req_rx_byte,
   // frame output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sefx_pkg::BYTE_W-1:0]       rsp_frame_byte,
   output logic                              rsp_frame_last,
   // configuration
   input  logic                              csr_write,
   input  sefx_pkg::csr_index_type           csr_index,
   input  logic [sefx_pkg::BYTE_W-1:0]       csr_wdata
);

   localparam int IDX_W = $clog2(WINDOW_BYTES);
   localparam int CNT_W = $clog2(WINDOW_BYTES + 1);
   localparam logic [CNT_W-1:0] HELD_FULL = CNT_W'(WINDOW_BYTES);
   localparam logic [IDX_W-1:0] ROT_LAST  = IDX_W'(WINDOW_BYTES - 1);

   // config
   logic [sefx_pkg::BYTE_W-1:0]  start_marker_ff, start_marker_in;
   logic [sefx_pkg::BYTE_W-1:0]  end_marker_ff, end_marker_in;
   logic [sefx_pkg::LIMIT_W-1:0] payload_limit_ff, payload_limit_in;

   // control
   sefx_pkg::state_type          state_ff, state_in;
   logic [CNT_W-1:0]             held_ff, held_in;
   logic [IDX_W-1:0]             rot_ff, rot_in;
   logic [sefx_pkg::SIZE_W-1:0]  size_ff, size_in;
   logic [sefx_pkg::SIZE_W-1:0]  emit_cnt_ff, emit_cnt_in;
   logic                         rescan_ff, rescan_in;
   logic                         probe_ff, probe_in;   // end byte fetched

   // cell chain
   logic [sefx_pkg::BYTE_W-1:0]  cell_q   [WINDOW_BYTES];
   sefx_pkg::cell_ctl_type       cell_ctl [WINDOW_BYTES];
   logic [sefx_pkg::BYTE_W-1:0]  wrap_byte;

   logic req_fire;
   logic slide;
   logic rotate;
   logic load_en;
   logic emit_last;

   // frame check at the head of the chain
   logic [sefx_pkg::BYTE_W-1:0]  head_byte;
   logic [sefx_pkg::BYTE_W-1:0]  len_byte;
   logic [sefx_pkg::BYTE_W-1:0]  end_byte_ff, end_byte_in;
   logic [9:0]                   frame_size;
   logic [8:0]                   end_off;
   logic                         fits;
   logic                         end_in_window;
   logic                         hit;

   assign req_ready = (state_ff == sefx_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slide     = req_fire && (held_ff == HELD_FULL);
   assign load_en   = req_fire && !slide;

   assign head_byte     = cell_q[0];
   assign len_byte      = cell_q[sefx_pkg::LEN_OFFSET];
   assign frame_size    = {2'b00, len_byte} + 10'(sefx_pkg::FRAME_OVERHEAD);
   assign end_off       = {1'b0, len_byte} + 9'(sefx_pkg::END_OFFSET);
   assign fits          = (10'(rot_ff) + frame_size) <= 10'(held_ff);
   assign end_in_window = end_off < 9'(WINDOW_BYTES);
   assign end_byte_in   = cell_q[end_off[IDX_W-1:0]];

   // chain holds still on the fetch cycle, so head and length still match
   assign hit = (state_ff == sefx_pkg::ST_SCAN) && probe_ff
             && (head_byte == start_marker_ff)
             && (len_byte <= {2'b00, payload_limit_ff})
             && fits && end_in_window
             && (end_byte_ff == end_marker_ff);

   // rotation: scan steps that miss, and each delivered frame byte
   assign rotate = ((state_ff == sefx_pkg::ST_SCAN) && probe_ff && !hit)
                || ((state_ff == sefx_pkg::ST_EMIT) && rsp_ready);

   assign wrap_byte = rotate ? cell_q[0] : req_rx_byte;

   always_comb begin
      for (int k = 0; k < WINDOW_BYTES; k++) begin
         cell_ctl[k].shift = rotate || slide;
         cell_ctl[k].load  = load_en && (held_ff[IDX_W-1:0] == IDX_W'(k));
      end
   end

   for (genvar g = 0; g < WINDOW_BYTES; g++) begin : g_cell
      logic [sefx_pkg::BYTE_W-1:0] right_byte;
      if (g == WINDOW_BYTES - 1) begin : g_tail
         assign right_byte = wrap_byte;
      end else begin : g_body
         assign right_byte = cell_q[g+1];
      end
      sefx_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[g]),
         .load_data  (req_rx_byte),
         .right_data (right_byte),
         .cell_byte  (cell_q[g])
      );
   end

   // output straight from the head cell; it holds while stalled
   assign emit_last      = (emit_cnt_ff == (size_ff - sefx_pkg::SIZE_W'(1)));
   assign rsp_valid      = (state_ff == sefx_pkg::ST_EMIT);
   assign rsp_frame_byte = cell_q[0];
   assign rsp_frame_last = emit_last;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      held_in     = held_ff;
      rot_in      = rot_ff;
      size_in     = size_ff;
      emit_cnt_in = emit_cnt_ff;
      rescan_in   = rescan_ff;
      probe_in    = probe_ff;

      unique case (state_ff)
         sefx_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (!slide) begin
                  held_in = held_ff + CNT_W'(1);
               end
               // without a config change only a frame ending here can appear
               if ((req_rx_byte == end_marker_ff) || rescan_ff) begin
                  state_in  = sefx_pkg::ST_SCAN;
                  rot_in    = '0;
                  rescan_in = 1'b0;
                  probe_in  = 1'b0;
               end
            end
         end
         sefx_pkg::ST_SCAN: begin
            if (!probe_ff) begin
               probe_in = 1'b1;
            end else begin
               probe_in = 1'b0;
               if (hit) begin
                  state_in    = sefx_pkg::ST_EMIT;
                  size_in     = frame_size[sefx_pkg::SIZE_W-1:0];
                  emit_cnt_in = '0;
               end else begin
                  rot_in = rot_ff + IDX_W'(1);
                  if (rot_ff == ROT_LAST) begin
                     state_in = sefx_pkg::ST_IDLE;   // full circle, order restored
                  end
               end
            end
         end
         sefx_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               emit_cnt_in = emit_cnt_ff + sefx_pkg::SIZE_W'(1);
               if (emit_last) begin
                  held_in  = '0;
                  state_in = sefx_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sefx_pkg::ST_IDLE;
         end
      endcase

      // any register write may complete an older frame
      if (csr_write) begin
         rescan_in = 1'b1;
      end
   end

   // config decode
   always_comb begin
      start_marker_in  = start_marker_ff;
      end_marker_in    = end_marker_ff;
      payload_limit_in = payload_limit_ff;
      if (csr_write) begin
         unique case (csr_index)
            sefx_pkg::REG_START_MARKER:  start_marker_in  = csr_wdata;
            sefx_pkg::REG_END_MARKER:    end_marker_in    = csr_wdata;
            sefx_pkg::REG_PAYLOAD_LIMIT:
               payload_limit_in = csr_wdata[sefx_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= sefx_pkg::ST_IDLE;
         held_ff          <= '0;
         rot_ff           <= '0;
         emit_cnt_ff      <= '0;
         rescan_ff        <= 1'b0;
         probe_ff         <= 1'b0;
         start_marker_ff  <= sefx_pkg::START_MARKER_RESET;
         end_marker_ff    <= sefx_pkg::END_MARKER_RESET;
         payload_limit_ff <= sefx_pkg::PAYLOAD_LIMIT_RESET;
      end else begin
         state_ff         <= state_in;
         held_ff          <= held_in;
         rot_ff           <= rot_in;
         emit_cnt_ff      <= emit_cnt_in;
         rescan_ff        <= rescan_in;
         probe_ff         <= probe_in;
         start_marker_ff  <= start_marker_in;
         end_marker_ff    <= end_marker_in;
         payload_limit_ff <= payload_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff     <= size_in;
      end_byte_ff <= end_byte_in;
   end

endmodule
